// ===== rtl/core/context_switched_rate_estimator_defines.svh =====
// Assertion macros used by the rate estimator checker.
`ifndef CONTEXT_SWITCHED_RATE_ESTIMATOR_DEFINES_SVH
`define CONTEXT_SWITCHED_RATE_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate estimator check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate estimator check failed");

`endif

// ===== rtl/core/cse_pkg.sv =====
// Shared types, widths and codes of the context-switched rate estimator.
package cse_pkg;

    localparam int MAX_INDEX_LIMIT_DEF = 127;
    localparam int COUNT_BITS_DEF      = 24;
    localparam int FRAC_BITS_DEF       = 10;

    localparam int SYM_W      = 8;
    localparam int MAXIDX_W   = 7;
    localparam int RATE_W     = 15;
    localparam int CTX_W      = 2;
    localparam int TOTAL_W    = 32;
    localparam int TOT_W      = TOTAL_W + 1;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int RATE_MAX   = 32767;

    localparam logic [MAXIDX_W-1:0] MAX_INDEX_RST = 7'd127;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CTX_W-1:0] CTX_ZERO = 2'd0;
    localparam logic [CTX_W-1:0] CTX_POS  = 2'd1;
    localparam logic [CTX_W-1:0] CTX_NEG  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_INDEX = 2'd0,
        CFG_FREEZE    = 2'd1
    } cfg_reg_e;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_NORM,
        B_MANT,
        B_DONE
    } back_state_e;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic                       kind;
        logic                       oor;
        logic [CTX_W-1:0]           ctx;
        logic signed [SYM_W-1:0]    sym;
        logic [MAXIDX_W-1:0]        emax;
        logic                       freeze;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/cse_front.sv =====
// Front end: configuration registers, input handshake, classification, context tracking.
module cse_front #(
    parameter int MAX_INDEX_LIMIT = cse_pkg::MAX_INDEX_LIMIT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              kind,
    input  logic signed [cse_pkg::SYM_W-1:0]  symbol_index,
    output logic                              busy,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cse_pkg::q_stat_t                  q_stat,
    input  logic                              clearing,
    output logic                              push,
    output cse_pkg::cmd_t                     push_cmd
);
    import cse_pkg::*;

    localparam int LIM_W = $clog2(MAX_INDEX_LIMIT + 1) + MAXIDX_W;

    logic [MAXIDX_W-1:0] max_index_reg;
    logic                freeze_reg;
    logic [CTX_W-1:0]    ctx_reg;
    logic [CTX_W-1:0]    ctx_next;
    logic [MAXIDX_W-1:0] emax;
    logic [SYM_W-1:0]    mag;
    logic                accept;

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full || clearing;
    assign accept    = start && !busy;
    assign push      = accept;

    always_comb
    begin
        if (LIM_W'(max_index_reg) > LIM_W'(MAX_INDEX_LIMIT))
            emax = MAXIDX_W'(MAX_INDEX_LIMIT);
        else
            emax = max_index_reg;
        // magnitude of -128 fits unsigned 8 bits
        mag = symbol_index[SYM_W-1] ? SYM_W'(-symbol_index) : SYM_W'(symbol_index);
    end

    always_comb
    begin
        push_cmd.kind   = kind;
        push_cmd.oor    = mag > SYM_W'(emax);
        push_cmd.ctx    = ctx_reg;
        push_cmd.sym    = symbol_index;
        push_cmd.emax   = emax;
        push_cmd.freeze = freeze_reg;
    end

    // Move the context on every accepted update beat, in range or not.
    always_comb
    begin
        ctx_next = ctx_reg;
        if (accept && kind)
        begin
            if (symbol_index == '0)
                ctx_next = CTX_ZERO;
            else if (!symbol_index[SYM_W-1])
                ctx_next = CTX_POS;
            else
                ctx_next = CTX_NEG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_index_reg <= MAX_INDEX_RST;
            freeze_reg    <= 1'b0;
            ctx_reg       <= CTX_ZERO;
        end
        else
        begin
            ctx_reg <= ctx_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_INDEX: max_index_reg <= cfg_data;
                    CFG_FREEZE:    freeze_reg    <= cfg_data[0];
                    default:       ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/cse_queue.sv =====
// Short command queue between the front and back ends.
module cse_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cse_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output cse_pkg::cmd_t    head,
    output cse_pkg::q_stat_t stat
);
    import cse_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign stat.empty = cnt_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/cse_back.sv =====
// Back end: count memory, totals, fixed-point log2 sequencer and result register.
module cse_back #(
    parameter int MAX_INDEX_LIMIT = cse_pkg::MAX_INDEX_LIMIT_DEF,
    parameter int COUNT_BITS      = cse_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS       = cse_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cse_pkg::cmd_t                 head,
    input  cse_pkg::q_stat_t              q_stat,
    output logic                          pop,
    output logic                          clearing,
    output logic                          done,
    output logic [cse_pkg::RATE_W-1:0]    rate_bits,
    output logic                          range_error,
    output logic [cse_pkg::CTX_W-1:0]     context_used
);
    import cse_pkg::*;

    localparam int SLOTS   = 2 * MAX_INDEX_LIMIT + 1;
    localparam int NUM_ENT = 3 * SLOTS;
    localparam int ADDR_W  = $clog2(NUM_ENT);
    localparam int WIDE_W  = ADDR_W + SYM_W;
    localparam int LOG_W   = POS_W + FRAC_BITS;
    localparam int CMP_W   = (LOG_W > RATE_W) ? LOG_W : RATE_W;

    localparam logic [ADDR_W-1:0] BASE_POS = ADDR_W'(SLOTS);
    localparam logic [ADDR_W-1:0] BASE_NEG = ADDR_W'(2 * SLOTS);

    back_state_e state_reg;
    back_state_e state_next;

    logic [COUNT_BITS-1:0] cnt_mem [NUM_ENT];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     addr_reg;
    cmd_t                  cmd_reg;
    logic [TOTAL_W-1:0]    totals_reg [3];
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      count_reg;
    logic [POS_W-1:0]      pt_reg;
    logic [POS_W-1:0]      pc_reg;
    logic [LOG_W-1:0]      lt_reg;
    logic [LOG_W-1:0]      lc_reg;
    logic                  done_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic                  oor_reg;
    logic [CTX_W-1:0]      ctx_out_reg;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     head_addr;
    logic [ADDR_W-1:0]     head_base;
    logic signed [WIDE_W-1:0] head_off;
    logic [TOTAL_W-1:0]    head_total;
    logic                  upd;
    logic                  clr_last;
    logic [LOG_W-1:0]      diff;
    logic [CMP_W-1:0]      diff_ext;
    logic [RATE_W-1:0]     rate_val;

    function automatic logic [POS_W-1:0] lead_pos(input logic [TOT_W-1:0] x);
        logic [POS_W-1:0] p;
        p = '0;
        for (int b = 0; b < TOT_W; b++)
            if (x[b])
                p = POS_W'(b);
        return p;
    endfunction

    // Linear mantissa: bits below the leading one, scaled to FRAC_BITS.
    function automatic logic [FRAC_BITS-1:0] mantissa(input logic [TOT_W-1:0] x,
                                                      input logic [POS_W-1:0] p);
        logic [TOT_W-1:0]           rest;
        logic [TOT_W+FRAC_BITS-1:0] sh;
        rest = x & ~(TOT_W'(1) << p);
        sh   = {rest, {FRAC_BITS{1'b0}}} >> p;
        return sh[FRAC_BITS-1:0];
    endfunction

    assign clearing     = state_reg == B_CLEAR;
    assign clr_last     = clr_addr_reg == ADDR_W'(NUM_ENT - 1);
    assign upd          = cmd_reg.kind && !cmd_reg.freeze && !cmd_reg.oor;
    assign done         = done_reg;
    assign rate_bits    = rate_reg;
    assign range_error  = oor_reg;
    assign context_used = ctx_out_reg;

    // Address and total of the item at the queue head.
    always_comb
    begin
        case (head.ctx)
            CTX_POS: head_base = BASE_POS;
            CTX_NEG: head_base = BASE_NEG;
            default: head_base = '0;
        endcase
        case (head.ctx)
            CTX_POS: head_total = totals_reg[1];
            CTX_NEG: head_total = totals_reg[2];
            default: head_total = totals_reg[0];
        endcase
        head_off  = WIDE_W'(head.sym) + WIDE_W'(MAX_INDEX_LIMIT);
        head_addr = head.oor ? '0 : head_base + ADDR_W'(head_off);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR: if (clr_last) state_next = B_IDLE;
            B_IDLE:  if (!q_stat.empty) state_next = B_NORM;
            B_NORM:  state_next = B_MANT;
            B_MANT:  state_next = B_DONE;
            B_DONE:  state_next = B_IDLE;
            default: state_next = B_CLEAR;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = (&rd_data_reg) ? rd_data_reg : rd_data_reg + 1'b1;
        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = COUNT_BITS'(1);
            end
            B_IDLE:  pop = !q_stat.empty;
            B_DONE:  mem_we = upd;
            default: ;
        endcase
    end

    always_comb
    begin
        diff     = (lt_reg > lc_reg) ? lt_reg - lc_reg : '0;
        diff_ext = CMP_W'(diff);
        if (cmd_reg.oor)
            rate_val = '0;
        else if (diff_ext > CMP_W'(RATE_MAX))
            rate_val = RATE_W'(RATE_MAX);
        else
            rate_val = RATE_W'(diff_ext);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[mem_waddr] <= mem_wdata;
        if (pop)
            rd_data_reg <= cnt_mem[head_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg   <= head;
            addr_reg  <= head_addr;
            total_reg <= TOT_W'(head_total) + TOT_W'({head.emax, 1'b1});
        end
        if (state_reg == B_NORM)
        begin
            // A zero count counts as one.
            count_reg <= (rd_data_reg == '0) ? TOT_W'(1) : TOT_W'(rd_data_reg);
            pt_reg    <= lead_pos(total_reg);
            pc_reg    <= lead_pos((rd_data_reg == '0) ? TOT_W'(1) : TOT_W'(rd_data_reg));
        end
        if (state_reg == B_MANT)
        begin
            lt_reg <= {pt_reg, mantissa(total_reg, pt_reg)};
            lc_reg <= {pc_reg, mantissa(count_reg, pc_reg)};
        end
        if (state_reg == B_DONE)
        begin
            rate_reg    <= rate_val;
            oor_reg     <= cmd_reg.oor;
            ctx_out_reg <= cmd_reg.ctx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            for (int c = 0; c < 3; c++)
                totals_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == B_DONE;
            if (clearing)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            // Bump the total of the active context, hold at all ones.
            if (state_reg == B_DONE && upd)
            begin
                case (cmd_reg.ctx)
                    CTX_POS: if (!(&totals_reg[1])) totals_reg[1] <= totals_reg[1] + 1'b1;
                    CTX_NEG: if (!(&totals_reg[2])) totals_reg[2] <= totals_reg[2] + 1'b1;
                    default: if (!(&totals_reg[0])) totals_reg[0] <= totals_reg[0] + 1'b1;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/context_switched_rate_estimator.sv =====
// Top level of the context-switched rate estimator.
// An item is taken on a clock edge with start high and busy low; each item gives exactly one
// result, shown for a single cycle with done high, and the receiver cannot stall it. The back
// end works one item at a time and takes no new one until the last is done; its steps are count
// memory read, leading-one search, mantissa and write-back. A result passes through the queue,
// the pop in B_IDLE, the B_NORM, B_MANT and B_DONE states and the done register. A two-entry
// queue lets the front keep accepting while the back end works; busy rises when it is full.
// After reset busy stays high while the count memory is filled with ones; configuration
// writes are taken at any time.
module context_switched_rate_estimator #(
    parameter int MAX_INDEX_LIMIT = cse_pkg::MAX_INDEX_LIMIT_DEF,
    parameter int COUNT_BITS      = cse_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS       = cse_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic signed [cse_pkg::SYM_W-1:0]  symbol_index,
    output logic                              done,
    output logic [cse_pkg::RATE_W-1:0]        rate_bits,
    output logic                              range_error,
    output logic [cse_pkg::CTX_W-1:0]         context_used,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cse_pkg::*;

    q_stat_t q_stat;
    cmd_t    push_cmd;
    cmd_t    head;
    logic    push;
    logic    pop;
    logic    clearing;

    cse_front #(
        .MAX_INDEX_LIMIT (MAX_INDEX_LIMIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .symbol_index (symbol_index),
        .busy         (busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_stat       (q_stat),
        .clearing     (clearing),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    cse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    cse_back #(
        .MAX_INDEX_LIMIT (MAX_INDEX_LIMIT),
        .COUNT_BITS      (COUNT_BITS),
        .FRAC_BITS       (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .clearing     (clearing),
        .done         (done),
        .rate_bits    (rate_bits),
        .range_error  (range_error),
        .context_used (context_used)
    );

endmodule

// ===== rtl/core/cse_checker.sv =====
// Port-level checks of the rate estimator and their bind to the top level.
`include "context_switched_rate_estimator_defines.svh"

module cse_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic [cse_pkg::RATE_W-1:0]    rate_bits,
    input logic                          range_error,
    input logic [cse_pkg::CTX_W-1:0]     context_used
);
    import cse_pkg::*;

    // Each beat passes the B_NORM, B_MANT and B_DONE states of the back end, so results never touch.
    `CSE_ASSERT_NEXT(a_done_spaced, done, !done)
    `CSE_ASSERT_NOW(a_oor_zero_rate, done && range_error, rate_bits == '0)
    `CSE_ASSERT_NOW(a_ctx_legal, done, context_used <= CTX_NEG)
    // Memory fill keeps the block busy right after reset.
    `CSE_ASSERT_NOW(a_busy_after_reset, !$past(rst_n), busy)

endmodule

bind context_switched_rate_estimator cse_checker u_cse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .done         (done),
    .rate_bits    (rate_bits),
    .range_error  (range_error),
    .context_used (context_used)
);
